>>> sv/a2p_pkg.sv
// ----------------------------------------------------------------------------
// a2p_pkg
// Shared constants, coefficient table and types of the atan2 degree pipeline.
// ----------------------------------------------------------------------------
package a2p_pkg;

   localparam int COORD_WIDTH_DEF     = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 6;

   // result field and its byte-padded bus width
   localparam int ANGLE_WIDTH = 15;
   localparam int RSP_WIDTH   = ((ANGLE_WIDTH + 7) / 8) * 8;

   // ratio in Q0.16, 0..65536 inclusive
   localparam int FRAC_BITS  = 16;
   localparam int QUOT_WIDTH = FRAC_BITS + 1;

   // polynomial terms in degrees, Q16, and their products with the ratio
   localparam int TERM_WIDTH = 24;
   localparam int PROD_WIDTH = TERM_WIDTH - 1 + QUOT_WIDTH;
   localparam int DEG_WIDTH  = 27;

   localparam logic [PROD_WIDTH-1:0] PROD_HALF = PROD_WIDTH'(32768);

   localparam logic signed [TERM_WIDTH-1:0] COEF_P7 = -24'sd166443;

   // constant added after each Horner product; the last product adds none
   localparam logic signed [TERM_WIDTH-1:0] HORNER_ADD [4] = '{
      24'sd584188,
      -24'sd1223390,
      24'sd3754140,
      24'sd0
   };

   localparam logic signed [DEG_WIDTH-1:0] DEG_90  = 27'sd5898240;
   localparam logic signed [DEG_WIDTH-1:0] DEG_180 = 27'sd11796480;
   localparam logic signed [DEG_WIDTH-1:0] DEG_360 = 27'sd23592960;

   typedef struct packed {
      logic zero;   // both coordinates zero
      logic swap;   // |y| > |x|
      logic xneg;
      logic yneg;
   } a2p_flags_type;

endpackage

>>> sv/a2p_divider.sv
// ----------------------------------------------------------------------------
// a2p_divider
// Pipelined restoring divider: ratio min/max as a rounded Q0.16 fraction,
// one quotient bit per stage after a numerator setup stage.
// ----------------------------------------------------------------------------
module a2p_divider #(
   parameter int COORD_WIDTH = a2p_pkg::COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_vld,
   input  logic [COORD_WIDTH-1:0]          in_lo,
   input  logic [COORD_WIDTH-1:0]          in_hi,
   input  a2p_pkg::a2p_flags_type          in_flags,
   output logic                            out_vld,
   output logic [a2p_pkg::QUOT_WIDTH-1:0]  out_quot,
   output a2p_pkg::a2p_flags_type          out_flags
);

   localparam int STEPS     = a2p_pkg::QUOT_WIDTH;
   localparam int NUM_WIDTH = COORD_WIDTH + a2p_pkg::FRAC_BITS;

   logic [NUM_WIDTH-1:0]   num_in;
   logic [STEPS:0]         vld_ff;
   logic [COORD_WIDTH-1:0] rem_ff   [STEPS+1];
   logic [STEPS-1:0]       low_ff   [STEPS+1];
   logic [COORD_WIDTH-1:0] hi_ff    [STEPS+1];
   logic [STEPS-1:0]       quot_ff  [STEPS+1];
   a2p_pkg::a2p_flags_type flags_ff [STEPS+1];

   logic [COORD_WIDTH:0]   trial    [STEPS];
   logic [COORD_WIDTH:0]   diff     [STEPS];
   logic                   qbit     [STEPS];
   logic [COORD_WIDTH-1:0] rem_in   [STEPS];

   // min * 2^16 + floor(max / 2)
   assign num_in = {in_lo, a2p_pkg::FRAC_BITS'(0)} + NUM_WIDTH'(in_hi >> 1);

   always_comb begin
      for (int k = 0; k < STEPS; k++) begin
         trial[k]  = {rem_ff[k], low_ff[k][STEPS-1-k]};
         diff[k]   = trial[k] - {1'b0, hi_ff[k]};
         qbit[k]   = (trial[k] >= {1'b0, hi_ff[k]});
         rem_in[k] = qbit[k] ? diff[k][COORD_WIDTH-1:0] : trial[k][COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STEPS-1:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]   <= COORD_WIDTH'(num_in >> STEPS);
         low_ff[0]   <= num_in[STEPS-1:0];
         hi_ff[0]    <= in_hi;
         quot_ff[0]  <= '0;
         flags_ff[0] <= in_flags;
         for (int k = 0; k < STEPS; k++) begin
            rem_ff[k+1]   <= rem_in[k];
            low_ff[k+1]   <= low_ff[k];
            hi_ff[k+1]    <= hi_ff[k];
            quot_ff[k+1]  <= {quot_ff[k][STEPS-2:0], qbit[k]};
            flags_ff[k+1] <= flags_ff[k];
         end
      end
   end

   assign out_vld   = vld_ff[STEPS];
   assign out_quot  = quot_ff[STEPS];
   assign out_flags = flags_ff[STEPS];

endmodule

>>> sv/a2p_poly.sv
// ----------------------------------------------------------------------------
// a2p_poly
// Odd seventh-order arctangent polynomial in Horner form: square, then four
// multiply / round-and-add stage pairs. Output is the octant angle in Q16.
// ----------------------------------------------------------------------------
module a2p_poly (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  logic                                   in_vld,
   input  logic [a2p_pkg::QUOT_WIDTH-1:0]         in_quot,
   input  a2p_pkg::a2p_flags_type                 in_flags,
   output logic                                   out_vld,
   output logic signed [a2p_pkg::TERM_WIDTH-1:0]  out_deg,
   output a2p_pkg::a2p_flags_type                 out_flags
);

   localparam int QW     = a2p_pkg::QUOT_WIDTH;
   localparam int TW     = a2p_pkg::TERM_WIDTH;
   localparam int PW     = a2p_pkg::PROD_WIDTH;
   localparam int SQW    = 2 * QW;
   localparam int HSTEPS = 4;
   localparam int STAGES = 2 + 2 * HSTEPS;

   logic [STAGES-1:0]      vld_ff;

   // square of the ratio
   logic [SQW-1:0]         sq_in;
   logic [SQW-1:0]         sq_ff;
   logic [QW-1:0]          sq_c_ff;
   a2p_pkg::a2p_flags_type sq_flags_ff;
   logic [SQW-1:0]         sq_rnd;

   // Horner entry of each step
   logic signed [TW-1:0]   t_ff     [HSTEPS+1];
   logic [QW-1:0]          c_ff     [HSTEPS+1];
   logic [QW-1:0]          c2_ff    [HSTEPS+1];
   a2p_pkg::a2p_flags_type flags_ff [HSTEPS+1];

   // product stage of each step
   logic [PW-1:0]          prod_ff  [HSTEPS];
   logic                   neg_ff   [HSTEPS];
   logic [QW-1:0]          mc_ff    [HSTEPS];
   logic [QW-1:0]          mc2_ff   [HSTEPS];
   a2p_pkg::a2p_flags_type mflags_ff[HSTEPS];

   logic [TW-2:0]          mag      [HSTEPS];
   logic [QW-1:0]          opnd     [HSTEPS];
   logic [PW-1:0]          prod_in  [HSTEPS];
   logic [PW-1:0]          rsum     [HSTEPS];
   logic signed [TW-1:0]   rmag     [HSTEPS];
   logic signed [TW-1:0]   t_in     [HSTEPS];

   assign sq_in  = {{QW{1'b0}}, in_quot} * {{QW{1'b0}}, in_quot};
   assign sq_rnd = sq_ff + SQW'(32768);

   always_comb begin
      for (int j = 0; j < HSTEPS; j++) begin
         mag[j]     = t_ff[j][TW-1] ? (TW-1)'(-t_ff[j]) : t_ff[j][TW-2:0];
         // last product is by the ratio itself, the others by its square
         opnd[j]    = (j == HSTEPS - 1) ? c_ff[j] : c2_ff[j];
         prod_in[j] = {{QW{1'b0}}, mag[j]} * {{(TW-1){1'b0}}, opnd[j]};
         rsum[j]    = prod_ff[j] + a2p_pkg::PROD_HALF;
         rmag[j]    = rsum[j][PW-1:a2p_pkg::FRAC_BITS];
         t_in[j]    = (neg_ff[j] ? -rmag[j] : rmag[j]) + a2p_pkg::HORNER_ADD[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff       <= sq_in;
         sq_c_ff     <= in_quot;
         sq_flags_ff <= in_flags;

         t_ff[0]     <= a2p_pkg::COEF_P7;
         c_ff[0]     <= sq_c_ff;
         c2_ff[0]    <= sq_rnd[QW+a2p_pkg::FRAC_BITS-1:a2p_pkg::FRAC_BITS];
         flags_ff[0] <= sq_flags_ff;

         for (int j = 0; j < HSTEPS; j++) begin
            prod_ff[j]    <= prod_in[j];
            neg_ff[j]     <= t_ff[j][TW-1];
            mc_ff[j]      <= c_ff[j];
            mc2_ff[j]     <= c2_ff[j];
            mflags_ff[j]  <= flags_ff[j];

            t_ff[j+1]     <= t_in[j];
            c_ff[j+1]     <= mc_ff[j];
            c2_ff[j+1]    <= mc2_ff[j];
            flags_ff[j+1] <= mflags_ff[j];
         end
      end
   end

   assign out_vld   = vld_ff[STAGES-1];
   assign out_deg   = t_ff[HSTEPS];
   assign out_flags = flags_ff[HSTEPS];

endmodule

>>> sv/atan2_degrees_polynomial.sv
// Throughput: one request per cycle; the 18-stage divider and the 10-stage
// polynomial pipeline are fully pipelined, and the whole pipe advances
// whenever the output register is empty or being taken.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
// ----------------------------------------------------------------------------
// atan2_degrees_polynomial
// Four-quadrant arctangent in degrees, scaled by 2^ANGLE_FRAC_BITS, from a
// divider ratio, an odd polynomial and octant reflection.
// ----------------------------------------------------------------------------
module atan2_degrees_polynomial #(
   parameter int COORD_WIDTH     = a2p_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_FRAC_BITS = a2p_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // x_coord, y_coord (zero pad above)
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // angle (zero pad above)
   output logic [a2p_pkg::RSP_WIDTH-1:0]      rsp_tdata
);

   localparam int W       = COORD_WIDTH;
   localparam int AW      = a2p_pkg::ANGLE_WIDTH;
   localparam int DW      = a2p_pkg::DEG_WIDTH;
   localparam int QW      = a2p_pkg::QUOT_WIDTH;
   localparam int TW      = a2p_pkg::TERM_WIDTH;
   localparam int SHIFT   = a2p_pkg::FRAC_BITS - ANGLE_FRAC_BITS;
   localparam int RSP_PAD = a2p_pkg::RSP_WIDTH - AW;
   localparam int MAX_ANGLE = 360 * (2 ** ANGLE_FRAC_BITS);

   logic adv;

   // front: magnitudes
   logic [W-1:0]           x_raw, y_raw, ax_in, ay_in;
   logic                   f1_vld_ff;
   logic [W-1:0]           ax_ff, ay_ff;
   logic                   xneg_ff, yneg_ff;

   // front: octant decision
   a2p_pkg::a2p_flags_type f2_flags_in;
   logic                   f2_vld_ff;
   logic [W-1:0]           lo_ff, hi_ff;
   a2p_pkg::a2p_flags_type f2_flags_ff;

   logic                   div_vld;
   logic [QW-1:0]          div_quot;
   a2p_pkg::a2p_flags_type div_flags;

   logic                   poly_vld;
   logic signed [TW-1:0]   poly_deg;
   a2p_pkg::a2p_flags_type poly_flags;

   // reflection
   logic signed [DW-1:0]   deg_ext, ra_deg_in;
   logic                   ra_vld_ff;
   logic signed [DW-1:0]   ra_deg_ff;
   a2p_pkg::a2p_flags_type ra_flags_ff;
   logic signed [DW-1:0]   rb_full;
   logic [DW-2:0]          rb_deg_in;
   logic                   rb_vld_ff;
   logic [DW-2:0]          rb_deg_ff;
   logic                   rb_zero_ff;

   // output
   logic [DW-1:0]          rnd_sum;
   logic [AW-1:0]          rsp_angle_in;
   logic                   rsp_vld_ff;
   logic [AW-1:0]          rsp_angle_ff;

   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv;

   assign x_raw = req_tdata[W-1:0];
   assign y_raw = req_tdata[2*W-1:W];
   assign ax_in = x_raw[W-1] ? (~x_raw + W'(1)) : x_raw;
   assign ay_in = y_raw[W-1] ? (~y_raw + W'(1)) : y_raw;

   always_comb begin
      f2_flags_in.zero = (ax_ff == '0) && (ay_ff == '0);
      f2_flags_in.swap = (ax_ff < ay_ff);
      f2_flags_in.xneg = xneg_ff;
      f2_flags_in.yneg = yneg_ff;
   end

   a2p_divider #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_vld    (f2_vld_ff),
      .in_lo     (lo_ff),
      .in_hi     (hi_ff),
      .in_flags  (f2_flags_ff),
      .out_vld   (div_vld),
      .out_quot  (div_quot),
      .out_flags (div_flags)
   );

   a2p_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_vld    (div_vld),
      .in_quot   (div_quot),
      .in_flags  (div_flags),
      .out_vld   (poly_vld),
      .out_deg   (poly_deg),
      .out_flags (poly_flags)
   );

   assign deg_ext = DW'(poly_deg);

   // first two reflections folded into one add
   always_comb begin
      unique case ({poly_flags.swap, poly_flags.xneg})
         2'b00:   ra_deg_in = deg_ext;
         2'b10:   ra_deg_in = a2p_pkg::DEG_90 - deg_ext;
         2'b01:   ra_deg_in = a2p_pkg::DEG_180 - deg_ext;
         default: ra_deg_in = a2p_pkg::DEG_90 + deg_ext;
      endcase
   end

   // lower half plane, then clamp at zero
   assign rb_full   = ra_flags_ff.yneg ? (a2p_pkg::DEG_360 - ra_deg_ff) : ra_deg_ff;
   assign rb_deg_in = rb_full[DW-1] ? '0 : rb_full[DW-2:0];

   assign rnd_sum      = {1'b0, rb_deg_ff} + (DW'(1) << (SHIFT - 1));
   assign rsp_angle_in = rb_zero_ff ? '0 : AW'(rnd_sum >> SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff  <= 1'b0;
         f2_vld_ff  <= 1'b0;
         ra_vld_ff  <= 1'b0;
         rb_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff  <= req_tvalid;
         f2_vld_ff  <= f1_vld_ff;
         ra_vld_ff  <= poly_vld;
         rb_vld_ff  <= ra_vld_ff;
         rsp_vld_ff <= rb_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff        <= ax_in;
         ay_ff        <= ay_in;
         xneg_ff      <= x_raw[W-1];
         yneg_ff      <= y_raw[W-1];

         lo_ff        <= f2_flags_in.swap ? ax_ff : ay_ff;
         hi_ff        <= f2_flags_in.swap ? ay_ff : ax_ff;
         f2_flags_ff  <= f2_flags_in;

         ra_deg_ff    <= ra_deg_in;
         ra_flags_ff  <= poly_flags;

         rb_deg_ff    <= rb_deg_in;
         rb_zero_ff   <= ra_flags_ff.zero;

         rsp_angle_ff <= rsp_angle_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_angle_ff};

   // ratio of min to max can never exceed one
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      div_vld && !div_flags.zero |-> div_quot <= QW'(65536))
      else $error("ratio above one");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (MAX_ANGLE < 32768) |-> 32'(rsp_angle_ff) <= MAX_ANGLE)
      else $error("angle above full circle");

   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      adv && rb_vld_ff && rb_zero_ff |=> rsp_tvalid && rsp_angle_ff == '0)
      else $error("zero point gave nonzero angle");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

>>> bench/atan2_degrees_polynomial_tb.sv
// ----------------------------------------------------------------------------
// atan2_degrees_polynomial_tb
// Drives coordinate pairs into the atan2 pipeline and checks every angle
// against a table value or a bit-exact fixed-point predictor. A short table of corner points
// runs first, then random points sent in bursts while the result side stalls.
// ----------------------------------------------------------------------------
module atan2_degrees_polynomial_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  COORD_W       = 16;
   localparam int  FRAC_W        = 6;
   localparam int  RANDOM_COUNT  = 1500;
   localparam int  DRAIN_CYCLES  = 64;
   localparam longint CYCLE_LIMIT = 400000;

   // octant polynomial coefficients in degrees, Q16
   localparam longint POLY_P1 = 3754140;
   localparam longint POLY_P3 = -1223390;
   localparam longint POLY_P5 = 584188;
   localparam longint POLY_P7 = -166443;
   localparam longint Q16_90  = 90 * 65536;
   localparam longint Q16_180 = 180 * 65536;
   localparam longint Q16_360 = 360 * 65536;

   typedef struct {
      logic signed [COORD_W-1:0]          x;
      logic signed [COORD_W-1:0]          y;
      logic                               known;
      logic [a2p_pkg::ANGLE_WIDTH-1:0]    angle;
   } point_row_type;

   localparam int CORNER_COUNT = 22;

   // known angles are filled in only where they follow directly
   point_row_type corner_points [CORNER_COUNT] = '{
      '{16'sd0,      16'sd0,      1'b1, 15'd0},      // both zero
      '{16'sd1,      16'sd0,      1'b1, 15'd0},
      '{16'sd0,      16'sd1,      1'b1, 15'd5760},
      '{-16'sd1,     16'sd0,      1'b1, 15'd11520},
      '{16'sd0,      -16'sd1,     1'b1, 15'd17280},
      '{16'sd32767,  16'sd0,      1'b1, 15'd0},
      '{16'sd0,      16'sd32767,  1'b1, 15'd5760},
      '{16'sh8000,   16'sd0,      1'b1, 15'd11520},
      '{16'sd0,      16'sh8000,   1'b1, 15'd17280},
      '{16'sd32767,  -16'sd1,     1'b1, 15'd23040},  // rounds up to full circle
      '{16'sd1,      16'sd1,      1'b0, 15'd0},      // equal magnitudes
      '{-16'sd1,     16'sd1,      1'b0, 15'd0},
      '{-16'sd1,     -16'sd1,     1'b0, 15'd0},
      '{16'sd1,      -16'sd1,     1'b0, 15'd0},
      '{16'sd32767,  16'sd32767,  1'b0, 15'd0},
      '{16'sh8000,   16'sh8000,   1'b0, 15'd0},
      '{16'sh8000,   16'sd32767,  1'b0, 15'd0},
      '{16'sd32767,  16'sh8000,   1'b0, 15'd0},
      '{16'sd12345,  -16'sd6789,  1'b0, 15'd0},
      '{-16'sd20000, 16'sd30000,  1'b0, 15'd0},
      '{16'sd3,      -16'sd7,     1'b0, 15'd0},
      '{-16'sd1,     16'sh8000,   1'b0, 15'd0}
   };

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [2*COORD_W-1:0]              req_tdata  = '0;   // x_coord, y_coord
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [a2p_pkg::RSP_WIDTH-1:0]     rsp_tdata;         // angle, zero pad

   logic [a2p_pkg::ANGLE_WIDTH-1:0]   pending_angles [$];
   int                                fail_count = 0;
   longint                            cycle_count = 0;

   logic [15:0]                       stall_pattern = 16'hFFFF;
   logic [3:0]                        stall_phase   = '0;

   atan2_degrees_polynomial DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // Q16 term times Q0.16 fraction, rounded to nearest, ties away from zero
   function automatic longint frac_product(longint term, longint frac);
      longint mag;
      mag = (term < 0) ? -term : term;
      mag = (mag * frac + 32768) >>> 16;
      return (term < 0) ? -mag : mag;
   endfunction

   function automatic logic [a2p_pkg::ANGLE_WIDTH-1:0] predict_angle(
      logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
      longint ax, ay, lo, hi, ratio, ratio_sq, poly, deg;
      ax = (x < 0) ? -longint'(x) : longint'(x);
      ay = (y < 0) ? -longint'(y) : longint'(y);
      if (ax == 0 && ay == 0)
         return '0;
      lo = (ax >= ay) ? ay : ax;
      hi = (ax >= ay) ? ax : ay;
      ratio    = ((lo <<< 16) + (hi >>> 1)) / hi;
      ratio_sq = (ratio * ratio + 32768) >>> 16;
      poly = frac_product(POLY_P7, ratio_sq) + POLY_P5;
      poly = frac_product(poly, ratio_sq) + POLY_P3;
      poly = frac_product(poly, ratio_sq) + POLY_P1;
      deg  = frac_product(poly, ratio);
      if (ax < ay)
         deg = Q16_90 - deg;
      if (x < 0)
         deg = Q16_180 - deg;
      if (y < 0)
         deg = Q16_360 - deg;
      if (deg < 0)
         deg = 0;
      deg = (deg + (longint'(1) <<< (15 - FRAC_W))) >>> (16 - FRAC_W);
      return deg[a2p_pkg::ANGLE_WIDTH-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return 16'sd0;
               1: return 16'sd1;
               2: return -16'sd1;
               3: return 16'sd32767;
               default: return 16'sh8000;
            endcase
         end
         1: return COORD_W'($urandom_range(0, 16)) - 16'sd8;
         2: return COORD_W'($urandom_range(0, 512)) - 16'sd256;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // hold the request until the pipe takes it, then log the angle it owes
   task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic known, logic [a2p_pkg::ANGLE_WIDTH-1:0] angle);
      req_tdata  <= {y, x};
      req_tvalid <= 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      pending_angles.push_back(known ? angle : predict_angle(x, y));
   endtask

   int burst_left = 0;

   // insert a gap between bursts; bursts of random length, some with no gap
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // result side: ready follows a 16-bit pattern, reshuffled when the cycle count's low byte is all ones
   always @(posedge clock) begin
      stall_phase <= stall_phase + 4'd1;
      rsp_tready  <= stall_pattern[stall_phase];
      if (cycle_count[7:0] == 8'hFF) begin
         case ($urandom_range(0, 3))
            0: stall_pattern <= 16'hFFFF;
            1: stall_pattern <= 16'($urandom) | 16'h0001;
            2: stall_pattern <= 16'($urandom) & 16'($urandom) | 16'h0001;
            default: stall_pattern <= 16'($urandom) | 16'($urandom);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[atan2_degrees_polynomial] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_angles.size() == 0) begin
            $error("unexpected angle %0d", rsp_tdata[a2p_pkg::ANGLE_WIDTH-1:0]);
            fail_count++;
         end else begin
            logic [a2p_pkg::ANGLE_WIDTH-1:0] want;
            want = pending_angles.pop_front();
            if (rsp_tdata[a2p_pkg::ANGLE_WIDTH-1:0] !== want) begin
               $error("angle: expected %0d, got %0d", want,
                      rsp_tdata[a2p_pkg::ANGLE_WIDTH-1:0]);
               fail_count++;
            end
            if (rsp_tdata[a2p_pkg::RSP_WIDTH-1:a2p_pkg::ANGLE_WIDTH] !== '0) begin
               $error("pad: expected 0, got %0h",
                      rsp_tdata[a2p_pkg::RSP_WIDTH-1:a2p_pkg::ANGLE_WIDTH]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      logic signed [COORD_W-1:0] x, y;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_points[i]) begin
         pace_sender();
         send_point(corner_points[i].x, corner_points[i].y,
                    corner_points[i].known, corner_points[i].angle);
      end

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         x = random_coord();
         y = random_coord();
         // force equal magnitudes now and then
         case ($urandom_range(0, 15))
            0: y = x;
            1: y = -x;
            default: ;
         endcase
         pace_sender();
         send_point(x, y, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (pending_angles.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("[atan2_degrees_polynomial] OK");
      else
         $display("[atan2_degrees_polynomial] ERROR");
      $finish;
   end

endmodule
